// ===== sv/sca_pkg.sv =====
// shared types, codes and defaults for the sound channel allocator
package sca_pkg;

  localparam int DEFAULT_MAX_CHANNELS = 8;
  localparam int DEFAULT_ORIGIN_BITS  = 16;

  // fixed field widths
  localparam int OPCODE_W  = 2;
  localparam int ORIGIN_W  = 16;
  localparam int PRIO_W    = 8;
  localparam int CHAN_W    = 3;
  localparam int COUNT_W   = 4;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  // request opcodes
  localparam logic [OPCODE_W-1:0] OP_ALLOC       = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_STOP_ORIGIN = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE_ONE    = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_FREE_ALL    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_FREE,
    ST_EVICT,
    ST_CLEAR,
    ST_ONE,
    ST_DONE
  } state_t;

endpackage

// ===== sv/sound_channel_allocator.sv =====
// sound channel allocator: voice table, scan sequencer and shared comparator
//
// Keeps an active flag, origin id and priority for each playback channel and
// serves one request at a time. A single comparator walks the table one channel
// per clock under a small sequencer: allocate runs up to three scans (stop the
// lowest channel of the same origin, find a free or same-origin channel, evict
// the lowest channel whose priority value is >= the request's). Stop by origin
// runs the first scan only, free all clears the table in one scan and free one
// channel reads its entry directly. in_stall is high while a request is being
// worked on; a finished result sits in an output register, so the next request
// is taken while it waits for the consumer. The channel count register is to be
// written only while the block is idle; the block itself does not enforce it.
// 0 acts as 1 and values above MAX_CHANNELS act as MAX_CHANNELS. Origin and
// priority of a channel that was never allocated are not defined.
module sound_channel_allocator #(
  parameter int MAX_CHANNELS = sca_pkg::DEFAULT_MAX_CHANNELS,
  parameter int ORIGIN_BITS  = sca_pkg::DEFAULT_ORIGIN_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [sca_pkg::COUNT_W-1:0]   cfg_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sca_pkg::OPCODE_W-1:0]  opcode,
  input  logic [sca_pkg::ORIGIN_W-1:0]  origin_id,
  input  logic [sca_pkg::PRIO_W-1:0]    sound_priority,
  input  logic [sca_pkg::CHAN_W-1:0]    channel_index,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          granted,
  output logic [sca_pkg::CHAN_W-1:0]    granted_channel,
  output logic                          stopped,
  output logic [sca_pkg::CHAN_W-1:0]    stopped_channel
);

  // stored origin width: the port never carries more than 16 bits
  localparam int OW    = (ORIGIN_BITS < sca_pkg::ORIGIN_W) ? ORIGIN_BITS : sca_pkg::ORIGIN_W;
  // count width holds MAX_CHANNELS itself, index width addresses the table
  localparam int CW    = $clog2(MAX_CHANNELS + 1);
  localparam int IW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  // shared comparator operand width
  localparam int CMPW  = (OW > sca_pkg::PRIO_W) ? OW : sca_pkg::PRIO_W;

  // channel table
  logic [MAX_CHANNELS-1:0]      ch_active;
  logic [MAX_CHANNELS-1:0]      ch_active_next;
  logic [OW-1:0]                ch_origin [MAX_CHANNELS];
  logic [sca_pkg::PRIO_W-1:0]   ch_prio   [MAX_CHANNELS];

  // configuration register
  logic [sca_pkg::COUNT_W-1:0]  active_channels;
  logic [CW-1:0]                n_ch;

  // latched request
  logic [sca_pkg::OPCODE_W-1:0] req_op;
  logic [OW-1:0]                req_origin;
  logic [sca_pkg::PRIO_W-1:0]   req_prio;
  logic [sca_pkg::CHAN_W-1:0]   req_idx;

  // sequencer
  sca_pkg::state_t              state;
  sca_pkg::state_t              state_next;
  logic [CW-1:0]                scan_idx;
  logic [CW-1:0]                scan_idx_next;

  // result being built
  logic                         work_grant;
  logic                         work_grant_next;
  logic [sca_pkg::CHAN_W-1:0]   work_grant_ch;
  logic [sca_pkg::CHAN_W-1:0]   work_grant_ch_next;
  logic                         work_stop;
  logic                         work_stop_next;
  logic [sca_pkg::CHAN_W-1:0]   work_stop_ch;
  logic [sca_pkg::CHAN_W-1:0]   work_stop_ch_next;

  // datapath controls
  logic [IW-1:0]                sel;
  logic [IW-1:0]                one_sel;
  logic                         scan_end;
  logic                         one_in_range;
  logic                         entry_wr;
  logic                         accept;
  logic                         load_out;
  logic [CMPW-1:0]              cmp_a;
  logic [CMPW-1:0]              cmp_b;
  logic                         cmp_eq;
  logic                         cmp_ge;
  logic                         hit_match;
  logic                         hit_free;
  logic [MAX_CHANNELS-1:0]      range_mask;

  // effective channel count, clamped to 1..MAX_CHANNELS
  always_comb begin
    if (active_channels == '0) begin
      n_ch = CW'(1);
    end else if (32'(active_channels) > 32'(MAX_CHANNELS)) begin
      n_ch = CW'(MAX_CHANNELS);
    end else begin
      n_ch = CW'(active_channels);
    end
  end

  // channels inside the configured count
  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      range_mask[i] = (32'(i) < 32'(n_ch));
    end
  end

  assign sel          = scan_idx[IW-1:0];
  assign one_sel      = IW'(req_idx);
  assign scan_end     = (scan_idx == n_ch);
  assign one_in_range = (32'(req_idx) < 32'(n_ch));

  assign in_stall = (state != sca_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (state == sca_pkg::ST_DONE) && (!out_valid || !out_stall);

  // shared comparator: priorities in the eviction scan, origins otherwise
  always_comb begin
    if (state == sca_pkg::ST_EVICT) begin
      cmp_a = CMPW'(ch_prio[sel]);
      cmp_b = CMPW'(req_prio);
    end else begin
      cmp_a = CMPW'(ch_origin[sel]);
      cmp_b = CMPW'(req_origin);
    end
  end

  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_ge = (cmp_a >= cmp_b);

  // origin 0 still matches in the stop step, never in the free search
  assign hit_match = ch_active[sel] && cmp_eq;
  assign hit_free  = !ch_active[sel] || ((req_origin != '0) && cmp_eq);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sca_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (opcode)
            sca_pkg::OP_ALLOC:       state_next = sca_pkg::ST_MATCH;
            sca_pkg::OP_STOP_ORIGIN: state_next = sca_pkg::ST_MATCH;
            sca_pkg::OP_FREE_ONE:    state_next = sca_pkg::ST_ONE;
            default:                 state_next = sca_pkg::ST_CLEAR;
          endcase
        end
      end
      sca_pkg::ST_MATCH: begin
        if (scan_end || hit_match) begin
          state_next = (req_op == sca_pkg::OP_ALLOC) ? sca_pkg::ST_FREE : sca_pkg::ST_DONE;
        end
      end
      sca_pkg::ST_FREE: begin
        if (scan_end) begin
          state_next = sca_pkg::ST_EVICT;
        end else if (hit_free) begin
          state_next = sca_pkg::ST_DONE;
        end
      end
      sca_pkg::ST_EVICT: begin
        if (scan_end || cmp_ge) begin
          state_next = sca_pkg::ST_DONE;
        end
      end
      sca_pkg::ST_CLEAR: begin
        if (scan_end) begin
          state_next = sca_pkg::ST_DONE;
        end
      end
      sca_pkg::ST_ONE: begin
        state_next = sca_pkg::ST_DONE;
      end
      sca_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = sca_pkg::ST_IDLE;
        end
      end
      default: state_next = sca_pkg::ST_IDLE;
    endcase
  end

  // datapath controls per state
  always_comb begin
    scan_idx_next      = scan_idx;
    ch_active_next     = ch_active;
    work_grant_next    = work_grant;
    work_grant_ch_next = work_grant_ch;
    work_stop_next     = work_stop;
    work_stop_ch_next  = work_stop_ch;
    entry_wr           = 1'b0;
    case (state)
      sca_pkg::ST_IDLE: begin
        scan_idx_next      = '0;
        work_grant_next    = 1'b0;
        work_grant_ch_next = '0;
        work_stop_next     = 1'b0;
        work_stop_ch_next  = '0;
      end
      sca_pkg::ST_MATCH: begin
        if (scan_end) begin
          scan_idx_next = '0;
        end else if (hit_match) begin
          ch_active_next[sel] = 1'b0;
          work_stop_next      = 1'b1;
          work_stop_ch_next   = sca_pkg::CHAN_W'(scan_idx);
          scan_idx_next       = '0;
        end else begin
          scan_idx_next = CW'(scan_idx + 1'b1);
        end
      end
      sca_pkg::ST_FREE: begin
        if (scan_end) begin
          scan_idx_next = '0;
        end else if (hit_free) begin
          // reuse of a same-origin channel counts as a stop
          if (ch_active[sel]) begin
            work_stop_next    = 1'b1;
            work_stop_ch_next = sca_pkg::CHAN_W'(scan_idx);
          end
          ch_active_next[sel] = 1'b1;
          entry_wr            = 1'b1;
          work_grant_next     = 1'b1;
          work_grant_ch_next  = sca_pkg::CHAN_W'(scan_idx);
        end else begin
          scan_idx_next = CW'(scan_idx + 1'b1);
        end
      end
      sca_pkg::ST_EVICT: begin
        if (!scan_end && cmp_ge) begin
          entry_wr           = 1'b1;
          work_stop_next     = 1'b1;
          work_stop_ch_next  = sca_pkg::CHAN_W'(scan_idx);
          work_grant_next    = 1'b1;
          work_grant_ch_next = sca_pkg::CHAN_W'(scan_idx);
        end else if (!scan_end) begin
          scan_idx_next = CW'(scan_idx + 1'b1);
        end
      end
      sca_pkg::ST_CLEAR: begin
        if (!scan_end) begin
          if (ch_active[sel]) begin
            ch_active_next[sel] = 1'b0;
            if (!work_stop) begin
              work_stop_next    = 1'b1;
              work_stop_ch_next = sca_pkg::CHAN_W'(scan_idx);
            end
          end
          scan_idx_next = CW'(scan_idx + 1'b1);
        end
      end
      sca_pkg::ST_ONE: begin
        if (one_in_range && ch_active[one_sel]) begin
          ch_active_next[one_sel] = 1'b0;
          work_stop_next          = 1'b1;
          work_stop_ch_next       = req_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= sca_pkg::ST_IDLE;
      scan_idx        <= '0;
      ch_active       <= '0;
      active_channels <= sca_pkg::COUNT_RESET;
      out_valid       <= 1'b0;
      work_grant      <= 1'b0;
      work_stop       <= 1'b0;
    end else begin
      state      <= state_next;
      scan_idx   <= scan_idx_next;
      ch_active  <= ch_active_next;
      work_grant <= work_grant_next;
      work_stop  <= work_stop_next;
      if (cfg_write) begin
        active_channels <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    work_grant_ch <= work_grant_ch_next;
    work_stop_ch  <= work_stop_ch_next;
    if (accept) begin
      req_op     <= opcode;
      req_origin <= origin_id[OW-1:0];
      req_prio   <= sound_priority;
      req_idx    <= channel_index;
    end
    if (load_out) begin
      granted         <= work_grant;
      granted_channel <= work_grant_ch;
      stopped         <= work_stop;
      stopped_channel <= work_stop_ch;
    end
  end

  // channel table entries
  always_ff @(posedge clk) begin
    if (entry_wr) begin
      ch_origin[sel] <= req_origin;
      ch_prio[sel]   <= req_prio;
    end
  end

  // the scan pointer never runs past the channel count
  assert property (@(posedge clk) disable iff (rst)
    (state == sca_pkg::ST_MATCH || state == sca_pkg::ST_FREE ||
     state == sca_pkg::ST_EVICT || state == sca_pkg::ST_CLEAR) |-> (scan_idx <= n_ch))
    else $error("scan pointer past channel count");

  // eviction is only reached with every channel in use
  assert property (@(posedge clk) disable iff (rst)
    (state == sca_pkg::ST_FREE && scan_end) |-> ((ch_active | ~range_mask) == '1))
    else $error("free search ended with a free channel");

  // free all leaves no channel in range active
  assert property (@(posedge clk) disable iff (rst)
    (state == sca_pkg::ST_CLEAR && scan_end) |-> ((ch_active & range_mask) == '0))
    else $error("free all left an active channel");

  // a result only appears from the done state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == sca_pkg::ST_DONE))
    else $error("result without finished request");

  // a grant always marks its channel active
  assert property (@(posedge clk) disable iff (rst)
    entry_wr |=> ch_active[$past(sel)])
    else $error("granted channel not active");

endmodule
